@@ design/pf_pkg.sv @@
`timescale 1ns / 1ps
// pf_pkg: sizes, codes and the command beat type shared by the packet FIFO.
// Depends on nothing; used by pf_front, pf_back and packet_fifo.

package pf_pkg;

	// Queue geometry
	localparam int SLOTS     = 16;
	localparam int MAX_BYTES = 64;

	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int IDX_W   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int LEN_W   = 7;
	localparam int ADDR_W  = SLOT_W + IDX_W;
	localparam int STORE_DEPTH = SLOTS * (2 ** IDX_W);

	// Fixed port widths
	localparam int FUNC_W     = 2;
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int OUT_CNT_W  = 5;

	// Command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Input operation codes
	localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_LONG  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_POP   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_CLEAR = 3'd5;

	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_POP,
		CMD_CLEAR
	} cmd_kind_t;

	typedef enum logic [1:0] {
		DROP_NONE,
		DROP_FULL,
		DROP_LONG
	} drop_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [BYTE_W-1:0]  data;
		logic               bvalid;
		logic               last;
	} cmd_t;

endpackage

@@ design/pf_ram.sv @@
`timescale 1ns / 1ps
// pf_ram: generic single-write, single-read RAM with registered read data.
// Standalone; holds the packet bytes.

module pf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  logic [WIDTH-1:0]          wr_data,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [WIDTH-1:0]          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ design/pf_front.sv @@
`timescale 1ns / 1ps
// pf_front: accepts input beats, decodes the operation and queues commands.
// Depends on pf_pkg.

module pf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pf_pkg::FUNC_W-1:0]    func,
	input  logic [pf_pkg::BYTE_W-1:0]    data_byte,
	input  logic                         byte_valid,
	input  logic                         last,
	output logic                         cmd_valid,
	output pf_pkg::cmd_t                 cmd,
	input  logic                         cmd_take
);

	pf_pkg::cmd_t                 q_mem_q [pf_pkg::Q_DEPTH];
	logic [pf_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [pf_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [pf_pkg::Q_CNT_W-1:0]   q_cnt_q;
	logic                         in_acc;
	logic                         keep;
	logic                         q_push;
	pf_pkg::cmd_t                 dec_cmd;

	// decode; an undefined code is swallowed
	always_comb begin
		dec_cmd.data   = data_byte;
		dec_cmd.bvalid = byte_valid;
		dec_cmd.last   = last;
		dec_cmd.kind   = pf_pkg::CMD_PUSH;
		keep           = 1'b1;
		unique case (func)
			pf_pkg::FUNC_PUSH:  dec_cmd.kind = pf_pkg::CMD_PUSH;
			pf_pkg::FUNC_POP:   dec_cmd.kind = pf_pkg::CMD_POP;
			pf_pkg::FUNC_CLEAR: dec_cmd.kind = pf_pkg::CMD_CLEAR;
			default:            keep         = 1'b0;
		endcase
	end

	assign in_stall  = (q_cnt_q == pf_pkg::Q_CNT_W'(pf_pkg::Q_DEPTH));
	assign in_acc    = in_valid && !in_stall;
	assign q_push    = in_acc && keep;
	assign cmd_valid = (q_cnt_q != '0);
	assign cmd       = q_mem_q[rd_ptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (q_push) begin
			q_mem_q[wr_ptr_q] <= dec_cmd;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= wr_ptr_q + pf_pkg::Q_PTR_W'(1);
			end
			if (cmd_take) begin
				rd_ptr_q <= rd_ptr_q + pf_pkg::Q_PTR_W'(1);
			end
			if (q_push && !cmd_take) begin
				q_cnt_q <= q_cnt_q + pf_pkg::Q_CNT_W'(1);
			end else if (cmd_take && !q_push) begin
				q_cnt_q <= q_cnt_q - pf_pkg::Q_CNT_W'(1);
			end
		end
	end

	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> q_cnt_q != '0)
		else $error("command taken from empty queue");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= pf_pkg::Q_CNT_W'(pf_pkg::Q_DEPTH))
		else $error("command queue overfilled");

endmodule

@@ design/pf_back.sv @@
`timescale 1ns / 1ps
// pf_back: executes queued commands: push bytes, pop streaming, clear.
// Depends on pf_pkg and pf_ram; holds slot pointers, lengths and result register.

module pf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  pf_pkg::cmd_t                   cmd,
	output logic                           cmd_take,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [pf_pkg::STATUS_W-1:0]    status,
	output logic [pf_pkg::BYTE_W-1:0]      out_byte,
	output logic                           out_valid,
	output logic                           out_last,
	output logic [pf_pkg::LEN_W-1:0]       packet_length,
	output logic                           queue_empty,
	output logic [pf_pkg::OUT_CNT_W-1:0]   stored_count
);

	typedef enum logic {
		ST_IDLE,
		ST_STREAM
	} state_t;

	state_t                         state_q;
	logic [pf_pkg::SLOT_W-1:0]      write_slot_q;
	logic [pf_pkg::SLOT_W-1:0]      read_slot_q;
	logic [pf_pkg::CNT_W-1:0]       count_q;
	logic [pf_pkg::LEN_W-1:0]       push_cnt_q;
	logic                           push_busy_q;
	pf_pkg::drop_t                  drop_q;
	logic [pf_pkg::SLOT_W-1:0]      slot_q;
	logic [pf_pkg::IDX_W-1:0]       idx_q;
	logic [pf_pkg::LEN_W-1:0]       len_q;
	logic [pf_pkg::LEN_W-1:0]       len_mem_q [pf_pkg::SLOTS];

	logic                           res_valid_q;
	logic [pf_pkg::STATUS_W-1:0]    res_status_q;
	logic [pf_pkg::BYTE_W-1:0]      res_byte_q;
	logic                           res_bvalid_q;
	logic                           res_last_q;
	logic [pf_pkg::LEN_W-1:0]       res_len_q;
	logic                           res_empty_q;
	logic [pf_pkg::OUT_CNT_W-1:0]   res_count_q;

	logic                           out_free;
	logic                           needs_out;
	pf_pkg::drop_t                  drop0;
	pf_pkg::drop_t                  drop1;
	logic [pf_pkg::LEN_W-1:0]       cnt0;
	logic [pf_pkg::LEN_W-1:0]       cnt1;
	logic                           push_ok;
	logic [pf_pkg::CNT_W-1:0]       count_after_push;
	logic [pf_pkg::STATUS_W-1:0]    push_status;
	logic [pf_pkg::LEN_W-1:0]       stored_len;
	logic [pf_pkg::LEN_W-1:0]       pop_len;
	logic [pf_pkg::CNT_W-1:0]       count_dec;
	logic                           stream_last;
	logic [pf_pkg::IDX_W-1:0]       rd_idx;
	logic                           ram_wr_en;
	logic [pf_pkg::ADDR_W-1:0]      ram_wr_addr;
	logic [pf_pkg::ADDR_W-1:0]      ram_rd_addr;
	logic [pf_pkg::BYTE_W-1:0]      ram_rd_data;

	function automatic logic [pf_pkg::SLOT_W-1:0] next_slot(
		input logic [pf_pkg::SLOT_W-1:0] s
	);
		next_slot = (s == pf_pkg::SLOT_W'(pf_pkg::SLOTS - 1)) ? '0 :
			s + pf_pkg::SLOT_W'(1);
	endfunction

	// issue control: a command that makes a result waits for a free result register
	assign out_free  = !res_valid_q || !res_stall;
	assign needs_out = !(cmd.kind == pf_pkg::CMD_PUSH && !cmd.last);
	assign cmd_take  = cmd_valid && (state_q == ST_IDLE) && (!needs_out || out_free);

	// push byte bookkeeping
	always_comb begin
		if (push_busy_q) begin
			drop0 = drop_q;
			cnt0  = push_cnt_q;
		end else begin
			drop0 = (count_q >= pf_pkg::CNT_W'(pf_pkg::SLOTS)) ?
				pf_pkg::DROP_FULL : pf_pkg::DROP_NONE;
			cnt0  = '0;
		end
		drop1     = drop0;
		cnt1      = cnt0;
		ram_wr_en = 1'b0;
		if (cmd.bvalid && drop0 == pf_pkg::DROP_NONE) begin
			if (cnt0 >= pf_pkg::LEN_W'(pf_pkg::MAX_BYTES)) begin
				drop1 = pf_pkg::DROP_LONG;
			end else begin
				cnt1      = cnt0 + pf_pkg::LEN_W'(1);
				ram_wr_en = cmd_take && (cmd.kind == pf_pkg::CMD_PUSH);
			end
		end
		push_ok          = (drop1 == pf_pkg::DROP_NONE);
		count_after_push = push_ok ? count_q + pf_pkg::CNT_W'(1) : count_q;
		case (drop1)
			pf_pkg::DROP_FULL: push_status = pf_pkg::STAT_FULL;
			pf_pkg::DROP_LONG: push_status = pf_pkg::STAT_LONG;
			default:           push_status = pf_pkg::STAT_OK;
		endcase
	end

	assign ram_wr_addr = {write_slot_q, cnt0[pf_pkg::IDX_W-1:0]};

	// pop length and streaming position
	assign stored_len  = len_mem_q[read_slot_q];
	assign pop_len     = (stored_len > pf_pkg::LEN_W'(pf_pkg::MAX_BYTES)) ?
		pf_pkg::LEN_W'(pf_pkg::MAX_BYTES) : stored_len;
	assign count_dec   = count_q - pf_pkg::CNT_W'(1);
	assign stream_last = (pf_pkg::LEN_W'(idx_q) + pf_pkg::LEN_W'(1)) == len_q;

	// read address runs one step ahead so the registered data meets idx_q
	always_comb begin
		rd_idx = idx_q;
		if (out_free) begin
			rd_idx = idx_q + pf_pkg::IDX_W'(1);
		end
		if (state_q == ST_STREAM) begin
			ram_rd_addr = {slot_q, rd_idx};
		end else begin
			ram_rd_addr = {read_slot_q, pf_pkg::IDX_W'(0)};
		end
	end

	pf_ram #(
		.WIDTH(pf_pkg::BYTE_W),
		.DEPTH(pf_pkg::STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(cmd.data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// length per slot, written when a packet is closed
	always_ff @(posedge clk) begin
		if (cmd_take && cmd.kind == pf_pkg::CMD_PUSH && cmd.last && push_ok) begin
			len_mem_q[write_slot_q] <= cnt1;
		end
	end

	// sequencer state, queue pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			write_slot_q <= '0;
			read_slot_q  <= '0;
			count_q      <= '0;
			push_cnt_q   <= '0;
			push_busy_q  <= 1'b0;
			drop_q       <= pf_pkg::DROP_NONE;
			slot_q       <= '0;
			idx_q        <= '0;
			len_q        <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= '0;
			res_byte_q   <= '0;
			res_bvalid_q <= 1'b0;
			res_last_q   <= 1'b0;
			res_len_q    <= '0;
			res_empty_q  <= 1'b1;
			res_count_q  <= '0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						unique case (cmd.kind)
							pf_pkg::CMD_PUSH: begin
								if (cmd.last) begin
									if (push_ok) begin
										write_slot_q <= next_slot(write_slot_q);
									end
									count_q      <= count_after_push;
									push_busy_q  <= 1'b0;
									drop_q       <= pf_pkg::DROP_NONE;
									push_cnt_q   <= '0;
									res_valid_q  <= 1'b1;
									res_status_q <= push_status;
									res_byte_q   <= '0;
									res_bvalid_q <= 1'b0;
									res_last_q   <= 1'b1;
									res_len_q    <= push_ok ? cnt1 : '0;
									res_empty_q  <= (count_after_push == '0);
									res_count_q  <= pf_pkg::OUT_CNT_W'(count_after_push);
								end else begin
									push_busy_q <= 1'b1;
									drop_q      <= drop1;
									push_cnt_q  <= cnt1;
								end
							end
							pf_pkg::CMD_POP: begin
								res_valid_q  <= 1'b1;
								res_byte_q   <= '0;
								res_bvalid_q <= 1'b0;
								res_last_q   <= 1'b1;
								res_len_q    <= '0;
								if (count_q == '0) begin
									res_status_q <= pf_pkg::STAT_EMPTY;
									res_empty_q  <= 1'b1;
									res_count_q  <= '0;
								end else begin
									read_slot_q  <= next_slot(read_slot_q);
									count_q      <= count_dec;
									res_status_q <= pf_pkg::STAT_POP;
									res_empty_q  <= (count_dec == '0);
									res_count_q  <= pf_pkg::OUT_CNT_W'(count_dec);
									if (pop_len != '0) begin
										// bytes follow from the stream state
										res_valid_q <= 1'b0;
										state_q     <= ST_STREAM;
										slot_q      <= read_slot_q;
										idx_q       <= '0;
										len_q       <= pop_len;
									end
								end
							end
							pf_pkg::CMD_CLEAR: begin
								read_slot_q  <= write_slot_q;
								count_q      <= '0;
								push_busy_q  <= 1'b0;
								drop_q       <= pf_pkg::DROP_NONE;
								push_cnt_q   <= '0;
								res_valid_q  <= 1'b1;
								res_status_q <= pf_pkg::STAT_CLEAR;
								res_byte_q   <= '0;
								res_bvalid_q <= 1'b0;
								res_last_q   <= 1'b1;
								res_len_q    <= '0;
								res_empty_q  <= 1'b1;
								res_count_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_STREAM: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						res_status_q <= pf_pkg::STAT_POP;
						res_byte_q   <= ram_rd_data;
						res_bvalid_q <= 1'b1;
						res_last_q   <= stream_last;
						res_len_q    <= len_q;
						res_empty_q  <= (count_q == '0);
						res_count_q  <= pf_pkg::OUT_CNT_W'(count_q);
						idx_q        <= rd_idx;
						if (stream_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign status        = res_status_q;
	assign out_byte      = res_byte_q;
	assign out_valid     = res_bvalid_q;
	assign out_last      = res_last_q;
	assign packet_length = res_len_q;
	assign queue_empty   = res_empty_q;
	assign stored_count  = res_count_q;

	a_stream_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STREAM |-> pf_pkg::LEN_W'(idx_q) < len_q)
		else $error("stream index past packet length");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pf_pkg::CNT_W'(pf_pkg::SLOTS))
		else $error("packet count above slot count");

	a_no_write_while_streaming: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> state_q == ST_IDLE)
		else $error("store written during a pop");

	a_stream_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STREAM && out_free && stream_last) |=>
		(state_q == ST_IDLE && res_last_q && res_bvalid_q))
		else $error("pop stream did not end on a flagged last byte");

endmodule

@@ design/packet_fifo.sv @@
`timescale 1ns / 1ps
// packet_fifo: top level of the variable-length packet FIFO.
// Depends on pf_pkg, pf_front, pf_back (and pf_ram through pf_back).
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_stall | func, data_byte, byte_valid, last
//  result   | res_valid/res_stall | status, out_byte, out_valid, out_last,
//           |                     | packet_length, queue_empty, stored_count
//
// The back end executes a push beat or a clear as soon as it takes it; a pop first
// looks up the slot and then streams one byte per cycle while results are not
// stalled, as the packet store has a single read port. A four-beat command queue
// lets the front keep taking beats while a pop streams or results are stalled.
// Reset clears pointers, counts and the queue at once; the packet store needs
// no clearing pass, its entries are only read after being written.

module packet_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pf_pkg::FUNC_W-1:0]      func,
	input  logic [pf_pkg::BYTE_W-1:0]      data_byte,
	input  logic                           byte_valid,
	input  logic                           last,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [pf_pkg::STATUS_W-1:0]    status,
	output logic [pf_pkg::BYTE_W-1:0]      out_byte,
	output logic                           out_valid,
	output logic                           out_last,
	output logic [pf_pkg::LEN_W-1:0]       packet_length,
	output logic                           queue_empty,
	output logic [pf_pkg::OUT_CNT_W-1:0]   stored_count
);

	logic          cmd_valid;
	logic          cmd_take;
	pf_pkg::cmd_t  cmd;

	// decode and command queue
	pf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.data_byte (data_byte),
		.byte_valid(byte_valid),
		.last      (last),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// execution and result register
	pf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.out_byte     (out_byte),
		.out_valid    (out_valid),
		.out_last     (out_last),
		.packet_length(packet_length),
		.queue_empty  (queue_empty),
		.stored_count (stored_count)
	);

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for packet_fifo, with a scoreboard class that models the packet queue.
// Depends on pf_pkg and packet_fifo; drives random push, pop and clear beats with random gaps and
// result stalls.

module tb;

	localparam logic [pf_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;	// undefined code, ignored by the block
	localparam int QUIET_LIMIT = 3000;
	localparam int N_ITEMS     = 450;

	// one result beat as seen on the result channel
	typedef struct packed {
		logic [pf_pkg::STATUS_W-1:0]  status;
		logic [pf_pkg::BYTE_W-1:0]    out_byte;
		logic                         out_valid;
		logic                         out_last;
		logic [pf_pkg::LEN_W-1:0]     length;
		logic                         empty;
		logic [pf_pkg::OUT_CNT_W-1:0] count;
	} fifo_beat_t;

	// packet queue model plus store of the result beats it predicts
	class fifo_scoreboard;
		logic [pf_pkg::BYTE_W-1:0] slot_bytes [pf_pkg::SLOTS][pf_pkg::MAX_BYTES];
		int                slot_len [pf_pkg::SLOTS];
		int                head, tail, held;
		int                fill_len;
		bit                filling;
		pf_pkg::drop_t     drop_why;
		fifo_beat_t        pending_results [$];
		int                errors, n_checked;
		int                n_ok, n_full, n_long, n_pop, n_empty, n_clear;

		function new();
			head = 0;
			tail = 0;
			held = 0;
			fill_len = 0;
			filling = 0;
			drop_why = pf_pkg::DROP_NONE;
			errors = 0;
			n_checked = 0;
			n_ok = 0;
			n_full = 0;
			n_long = 0;
			n_pop = 0;
			n_empty = 0;
			n_clear = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// occupancy fields reflect the queue after the command
		function void queue_result(fifo_beat_t r);
			r.empty = (held == 0);
			r.count = pf_pkg::OUT_CNT_W'(held);
			pending_results.insert(pending_results.size(), r);
		endfunction

		// work out the result beats of one accepted command beat
		function void take_command(logic [pf_pkg::FUNC_W-1:0] f, logic [pf_pkg::BYTE_W-1:0] b,
				logic bv, logic lst);
			fifo_beat_t r;
			int         s, n;
			r = '0;
			r.out_last = 1'b1;
			case (f)
			pf_pkg::FUNC_PUSH: begin
				if (!filling) begin
					filling = 1'b1;
					fill_len = 0;
					drop_why = (held >= pf_pkg::SLOTS) ? pf_pkg::DROP_FULL : pf_pkg::DROP_NONE;
				end
				// a full drop found first stays the reason
				if (bv && drop_why == pf_pkg::DROP_NONE) begin
					if (fill_len >= pf_pkg::MAX_BYTES)
						drop_why = pf_pkg::DROP_LONG;
					else begin
						slot_bytes[tail][fill_len] = b;
						fill_len++;
					end
				end
				if (lst) begin
					case (drop_why)
					pf_pkg::DROP_FULL: begin
						r.status = pf_pkg::STAT_FULL;
						n_full++;
					end
					pf_pkg::DROP_LONG: begin
						r.status = pf_pkg::STAT_LONG;
						n_long++;
					end
					default: begin
						r.status = pf_pkg::STAT_OK;
						r.length = pf_pkg::LEN_W'(fill_len);
						slot_len[tail] = fill_len;
						tail = (tail + 1) % pf_pkg::SLOTS;
						held++;
						n_ok++;
					end
					endcase
					filling = 0;
					fill_len = 0;
					drop_why = pf_pkg::DROP_NONE;
					queue_result(r);
				end
			end
			pf_pkg::FUNC_POP: begin
				if (held == 0) begin
					r.status = pf_pkg::STAT_EMPTY;
					n_empty++;
					queue_result(r);
				end else begin
					// packet in progress is not visible to the pop
					s = head;
					n = slot_len[s];
					head = (head + 1) % pf_pkg::SLOTS;
					held--;
					n_pop++;
					r.status = pf_pkg::STAT_POP;
					if (n == 0)
						queue_result(r);
					else begin
						for (int i = 0; i < n; i++) begin
							r.out_byte = slot_bytes[s][i];
							r.out_valid = 1'b1;
							r.out_last = (i == n - 1);
							r.length = pf_pkg::LEN_W'(n);
							queue_result(r);
						end
					end
				end
			end
			pf_pkg::FUNC_CLEAR: begin
				head = tail;
				held = 0;
				filling = 0;
				fill_len = 0;
				drop_why = pf_pkg::DROP_NONE;
				n_clear++;
				r.status = pf_pkg::STAT_CLEAR;
				queue_result(r);
			end
			default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("ERROR @%0t: %s", $time, msg);
		endtask

		task compare_field(string name, int got_v, int want_v);
			if (got_v != want_v)
				report($sformatf("result %0d: %s is %0d, expected %0d", n_checked, name,
					got_v, want_v));
		endtask

		// compare an accepted result beat with the oldest expectation
		task check_result(fifo_beat_t got);
			fifo_beat_t want;
			n_checked++;
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", n_checked));
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			compare_field("status", got.status, want.status);
			compare_field("out_byte", got.out_byte, want.out_byte);
			compare_field("out_valid", got.out_valid, want.out_valid);
			compare_field("out_last", got.out_last, want.out_last);
			compare_field("packet_length", got.length, want.length);
			compare_field("queue_empty", got.empty, want.empty);
			compare_field("stored_count", got.count, want.count);
		endtask
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [pf_pkg::FUNC_W-1:0]    func;
	logic [pf_pkg::BYTE_W-1:0]    data_byte;
	logic                         byte_valid;
	logic                         last;
	logic                         res_valid;
	logic                         res_stall = 1'b0;
	logic [pf_pkg::STATUS_W-1:0]  status;
	logic [pf_pkg::BYTE_W-1:0]    out_byte;
	logic                         out_valid;
	logic                         out_last;
	logic [pf_pkg::LEN_W-1:0]     packet_length;
	logic                         queue_empty;
	logic [pf_pkg::OUT_CNT_W-1:0] stored_count;

	fifo_scoreboard sb;
	fifo_beat_t     seen;
	logic           calm = 1'b0;	// no gaps and no stalls while set
	int             n_items;
	int             quiet_cycles;
	int             pop_pct;
	int             pick;
	int             phase_pop [5] = '{5, 35, 20, 50, 30};

	packet_fifo u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.out_byte     (out_byte),
		.out_valid    (out_valid),
		.out_last     (out_last),
		.packet_length(packet_length),
		.queue_empty  (queue_empty),
		.stored_count (stored_count)
	);

	always #5 clk = ~clk;

	// result side: check each accepted beat, stall at random
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			seen.status = status;
			seen.out_byte = out_byte;
			seen.out_valid = out_valid;
			seen.out_last = out_last;
			seen.length = packet_length;
			seen.empty = queue_empty;
			seen.count = stored_count;
			sb.check_result(seen);
		end
		res_stall <= !calm && ($urandom_range(99) < 30);
	end

	// watchdog on cycles in which no beat moves
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles without a beat moving", QUIET_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// one command beat, after an optional gap; returns at the accepting edge
	task automatic send(logic [pf_pkg::FUNC_W-1:0] f, logic [pf_pkg::BYTE_W-1:0] b, logic bv,
			logic lst);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 30)
			gap = $urandom_range(1, 2);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		data_byte <= b;
		byte_valid <= bv;
		last <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_command(f, b, bv, lst);
		if (f != FUNC_NONE)
			n_items++;
	endtask

	// sender holds off until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// well-formed packet, sometimes with empty fillers and a closing empty marker
	task automatic push_packet(int nbytes);
		bit end_marker;
		end_marker = (nbytes == 0) || ($urandom_range(3) == 0);
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(9) == 0)
				send(pf_pkg::FUNC_PUSH, 8'($urandom), 1'b0, 1'b0);
			send(pf_pkg::FUNC_PUSH, 8'($urandom), 1'b1, !end_marker && (i == nbytes - 1));
		end
		if (end_marker)
			send(pf_pkg::FUNC_PUSH, 8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		sb = new();
		n_items = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = pf_pkg::FUNC_PUSH;
		data_byte = '0;
		byte_valid = 1'b0;
		last = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, zero-length, byte extremes, ignored code
		send(pf_pkg::FUNC_POP, 8'h00, 1'b0, 1'b0);
		send(pf_pkg::FUNC_PUSH, 8'h00, 1'b0, 1'b1);
		send(pf_pkg::FUNC_PUSH, 8'hFF, 1'b1, 1'b1);
		send(pf_pkg::FUNC_PUSH, 8'h00, 1'b1, 1'b0);
		send(pf_pkg::FUNC_PUSH, 8'hFF, 1'b0, 1'b0);
		send(pf_pkg::FUNC_PUSH, 8'hA5, 1'b1, 1'b1);
		send(FUNC_NONE, 8'hFF, 1'b1, 1'b1);
		send(pf_pkg::FUNC_POP, 8'hFF, 1'b1, 1'b1);
		send(pf_pkg::FUNC_POP, 8'h5A, 1'b0, 1'b0);
		send(pf_pkg::FUNC_POP, 8'h00, 1'b0, 1'b1);
		// pop while a push is open, then the push completes
		send(pf_pkg::FUNC_PUSH, 8'h7E, 1'b1, 1'b0);
		send(pf_pkg::FUNC_POP, 8'h00, 1'b0, 1'b0);
		send(pf_pkg::FUNC_PUSH, 8'h81, 1'b1, 1'b1);
		send(pf_pkg::FUNC_POP, 8'h00, 1'b0, 1'b0);
		// clear aborts an open push, and clear on a non-empty queue
		send(pf_pkg::FUNC_PUSH, 8'h3C, 1'b1, 1'b0);
		send(pf_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b0);
		send(pf_pkg::FUNC_POP, 8'h00, 1'b0, 1'b0);
		send(pf_pkg::FUNC_PUSH, 8'hC3, 1'b1, 1'b1);
		send(pf_pkg::FUNC_CLEAR, 8'hFF, 1'b1, 1'b1);
		send(pf_pkg::FUNC_POP, 8'h00, 1'b0, 1'b0);
		drain();

		// fill every slot, then one more packet that finds the queue full
		for (int k = 0; k <= pf_pkg::SLOTS; k++)
			push_packet(1);
		drain();

		// random phases, with pop shares ranging from push-heavy (fills the queue) to pop-heavy
		for (int ph = 0; ph < 5; ph++) begin
			pop_pct = phase_pop[ph];
			calm <= (ph == 2);
			while (n_items < 20 + (ph + 1) * (N_ITEMS - 20) / 5) begin
				pick = $urandom_range(99);
				if (pick < pop_pct)
					send(pf_pkg::FUNC_POP, 8'($urandom), 1'($urandom), 1'($urandom));
				else if (pick < pop_pct + 5)
					send(pf_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
				else if (pick < pop_pct + 9)
					send(FUNC_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
				else if (pick < pop_pct + 14)
					// open push left hanging for later commands
					repeat ($urandom_range(1, 3))
						send(pf_pkg::FUNC_PUSH, 8'($urandom), 1'($urandom), 1'b0);
				else if ($urandom_range(99) < 8)
					push_packet($urandom_range(pf_pkg::MAX_BYTES - 4, pf_pkg::MAX_BYTES + 2));
				else
					push_packet($urandom_range(0, 6));
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("Covered %0d command beats and %0d result beats: %0d packets stored,",
			n_items, sb.n_checked, sb.n_ok);
		$display("%0d dropped full, %0d dropped too long, %0d popped, %0d empty pops, %0d clears.",
			sb.n_full, sb.n_long, sb.n_pop, sb.n_empty, sb.n_clear);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
